/* rtl/core/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths, types, constants and the arctangent table for the bearing
// core.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int COORD_WIDTH       = 16;
  localparam int CORDIC_ITERATIONS = 20;

  localparam int TABLE_LEN  = 28;
  localparam int N_ITER     = (CORDIC_ITERATIONS > TABLE_LEN) ? TABLE_LEN : CORDIC_ITERATIONS;
  localparam int VEC_SHIFT  = 24;
  localparam int ANG_FRAC   = 16;
  localparam int DIFF_W     = COORD_WIDTH + 1;
  // scaled difference plus headroom for the CORDIC gain and the sqrt(2) diagonal
  localparam int VEC_W      = DIFF_W + VEC_SHIFT + 3;
  localparam int ANG_W      = 33;
  localparam int HEADING_W  = 16;
  localparam int ROUND_W    = ANG_W - 1 - ANG_FRAC + 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [VEC_W-1:0]       vec_t;
  typedef logic signed [ANG_W-1:0]       ang_t;
  typedef logic [ANG_W-2:0]              angu_t;
  typedef logic [ROUND_W-1:0]            round_t;
  typedef logic [HEADING_W-1:0]          heading_t;

  localparam ang_t   HALF_TURN = ANG_W'(64'd18000 << ANG_FRAC);
  localparam ang_t   FULL_TURN = ANG_W'(64'd36000 << ANG_FRAC);
  localparam round_t TURN_CDEG = ROUND_W'(36000);

  // per-stage control that travels with each item
  typedef struct packed {
    logic valid;
    logic zero;   // both differences zero: heading forced to 0
  } bpc_ctl_t;

  // atan(2^-i) in units of 2^-16 centidegree
  function automatic ang_t atan_entry(input int i);
    ang_t v;
    case (i)
      0:       v = ANG_W'(294912000);
      1:       v = ANG_W'(174096719);
      2:       v = ANG_W'(91987925);
      3:       v = ANG_W'(46694507);
      4:       v = ANG_W'(23437865);
      5:       v = ANG_W'(11730358);
      6:       v = ANG_W'(5866610);
      7:       v = ANG_W'(2933484);
      8:       v = ANG_W'(1466765);
      9:       v = ANG_W'(733385);
      10:      v = ANG_W'(366693);
      11:      v = ANG_W'(183346);
      12:      v = ANG_W'(91673);
      13:      v = ANG_W'(45837);
      14:      v = ANG_W'(22918);
      15:      v = ANG_W'(11459);
      16:      v = ANG_W'(5730);
      17:      v = ANG_W'(2865);
      18:      v = ANG_W'(1432);
      19:      v = ANG_W'(716);
      20:      v = ANG_W'(358);
      21:      v = ANG_W'(179);
      22:      v = ANG_W'(90);
      23:      v = ANG_W'(45);
      24:      v = ANG_W'(22);
      25:      v = ANG_W'(11);
      26:      v = ANG_W'(6);
      27:      v = ANG_W'(3);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/bpc_prep.sv */
// ----------------------------------------------------------------------------
// bpc_prep
// Two stages: coordinate differences, then scaling into the CORDIC vector
// (dy, -dx) with the half-turn pre-rotation for a negative x.
// ----------------------------------------------------------------------------
module bpc_prep
  import bpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      valid_i,
  input  coord_t    robot_x,
  input  coord_t    robot_y,
  input  coord_t    goal_x,
  input  coord_t    goal_y,
  output bpc_ctl_t  ctl_o,
  output vec_t      x_o,
  output vec_t      y_o,
  output ang_t      z_o
);

  logic  valid_a_r;
  diff_t dx_r, dy_r;
  diff_t dx_nxt, dy_nxt;

  bpc_ctl_t ctl_r, ctl_nxt;
  vec_t     x_r, y_r, x_nxt, y_nxt;
  ang_t     z_r, z_nxt;
  vec_t     dx_s, dy_s;

  assign dx_nxt = diff_t'({goal_x[COORD_WIDTH-1], goal_x})
                - diff_t'({robot_x[COORD_WIDTH-1], robot_x});
  assign dy_nxt = diff_t'({goal_y[COORD_WIDTH-1], goal_y})
                - diff_t'({robot_y[COORD_WIDTH-1], robot_y});

  always_comb begin
    dx_s          = vec_t'(dx_r) <<< VEC_SHIFT;
    dy_s          = vec_t'(dy_r) <<< VEC_SHIFT;
    ctl_nxt.valid = valid_a_r;
    ctl_nxt.zero  = (dx_r == '0) && (dy_r == '0);
    if (dy_r[DIFF_W-1]) begin
      // turn by a half circle so the vector lies in the right half plane
      x_nxt = -dy_s;
      y_nxt = dx_s;
      z_nxt = HALF_TURN;
    end else begin
      x_nxt = dy_s;
      y_nxt = -dx_s;
      z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      ctl_r     <= '0;
    end else if (en) begin
      valid_a_r <= valid_i;
      ctl_r     <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      z_r  <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

/* rtl/core/bpc_cordic.sv */
// ----------------------------------------------------------------------------
// bpc_cordic
// Vectoring CORDIC, one registered micro-rotation per stage. Each stage
// turns the vector toward y = 0 and accumulates the angle.
// ----------------------------------------------------------------------------
module bpc_cordic
  import bpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  bpc_ctl_t  ctl_i,
  input  vec_t      x_i,
  input  vec_t      y_i,
  input  ang_t      z_i,
  output bpc_ctl_t  ctl_o,
  output ang_t      z_o
);

  bpc_ctl_t ctl_r [N_ITER];
  vec_t     x_r   [N_ITER];
  vec_t     y_r   [N_ITER];
  ang_t     z_r   [N_ITER];

  bpc_ctl_t ctl_in [N_ITER];
  vec_t     x_in   [N_ITER];
  vec_t     y_in   [N_ITER];
  ang_t     z_in   [N_ITER];
  vec_t     x_nxt  [N_ITER];
  vec_t     y_nxt  [N_ITER];
  ang_t     z_nxt  [N_ITER];
  logic [N_ITER-1:0] dir_pos;

  for (genvar k = 0; k < N_ITER; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign ctl_in[k] = ctl_i;
      assign x_in[k]   = x_i;
      assign y_in[k]   = y_i;
      assign z_in[k]   = z_i;
    end else begin : g_next
      assign ctl_in[k] = ctl_r[k-1];
      assign x_in[k]   = x_r[k-1];
      assign y_in[k]   = y_r[k-1];
      assign z_in[k]   = z_r[k-1];
    end

    // y == 0 takes the negative direction
    assign dir_pos[k] = !y_in[k][VEC_W-1] && (y_in[k] != '0);
    assign x_nxt[k]   = dir_pos[k] ? x_in[k] + (y_in[k] >>> k) : x_in[k] - (y_in[k] >>> k);
    assign y_nxt[k]   = dir_pos[k] ? y_in[k] - (x_in[k] >>> k) : y_in[k] + (x_in[k] >>> k);
    assign z_nxt[k]   = dir_pos[k] ? z_in[k] + atan_entry(k) : z_in[k] - atan_entry(k);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N_ITER; k++) begin
        ctl_r[k] <= '0;
      end
    end else if (en) begin
      for (int k = 0; k < N_ITER; k++) begin
        ctl_r[k] <= ctl_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N_ITER; k++) begin
        x_r[k] <= x_nxt[k];
        y_r[k] <= y_nxt[k];
        z_r[k] <= z_nxt[k];
      end
    end
  end

  assign ctl_o = ctl_r[N_ITER-1];
  assign z_o   = z_r[N_ITER-1];

endmodule

/* rtl/core/bpc_post.sv */
// ----------------------------------------------------------------------------
// bpc_post
// Two stages: wrap the angle into one turn, then round to centidegrees.
// The second stage is the block's output register.
// ----------------------------------------------------------------------------
module bpc_post
  import bpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  bpc_ctl_t  ctl_i,
  input  ang_t      z_i,
  output logic      valid_o,
  output heading_t  heading_o
);

  bpc_ctl_t ctl_r;
  angu_t    zw_r, zw_nxt;
  ang_t     zs;
  logic     valid_r;
  heading_t heading_r, heading_nxt;
  round_t   rnd;

  always_comb begin
    if (z_i[ANG_W-1]) begin
      zs = z_i + FULL_TURN;
    end else if (z_i >= FULL_TURN) begin
      zs = z_i - FULL_TURN;
    end else begin
      zs = z_i;
    end
    zw_nxt = zs[ANG_W-2:0];
  end

  // add one half, drop the fraction
  assign rnd = round_t'(zw_r[ANG_W-2:ANG_FRAC]) + round_t'(zw_r[ANG_FRAC-1]);

  always_comb begin
    if (ctl_r.zero) begin
      heading_nxt = '0;
    end else if (rnd >= TURN_CDEG) begin
      heading_nxt = HEADING_W'(rnd - TURN_CDEG);
    end else begin
      heading_nxt = HEADING_W'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r   <= '0;
      valid_r <= 1'b0;
    end else if (en) begin
      ctl_r   <= ctl_i;
      valid_r <= ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zw_r      <= zw_nxt;
      heading_r <= heading_nxt;
    end
  end

  assign valid_o   = valid_r;
  assign heading_o = heading_r;

endmodule

/* rtl/core/bearing_to_point_centidegrees_core.sv */
// ----------------------------------------------------------------------------
// bearing_to_point_centidegrees_core
// Heading from a robot position toward a target, in centidegrees.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_ready): robot and target positions, signed mm.
// Output channel (out_valid / out_ready): heading 0..35999 centidegrees,
// 0 along +Y, 9000 along -X. Equal positions give 0.
// The pipeline is 24 stages deep: two for differences and pre-rotation,
// one per CORDIC micro-rotation (20), two for wrap and rounding.
// The accepting edge loads the first stage. One item is accepted per
// cycle while the output is not stalled; the rate is set by the fully
// unrolled CORDIC.
// All stages advance together whenever the output register is empty or
// being read, so in_ready follows out_ready while a result is held.
// A stalled receiver freezes every stage in place: nothing is lost or
// repeated, and items already in flight resume when out_ready returns.
// Synchronous reset clears all stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module bearing_to_point_centidegrees_core
  import bpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  coord_t   in_robot_x,
  input  coord_t   in_robot_y,
  input  coord_t   in_goal_x,
  input  coord_t   in_goal_y,
  output logic     out_valid,
  input  logic     out_ready,
  output heading_t out_heading_centideg
);

  logic     adv;
  bpc_ctl_t prep_ctl, cordic_ctl;
  vec_t     prep_x, prep_y;
  ang_t     prep_z, cordic_z;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  bpc_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .valid_i  (in_valid),
    .robot_x  (in_robot_x),
    .robot_y  (in_robot_y),
    .goal_x   (in_goal_x),
    .goal_y   (in_goal_y),
    .ctl_o    (prep_ctl),
    .x_o      (prep_x),
    .y_o      (prep_y),
    .z_o      (prep_z)
  );

  bpc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .ctl_i (prep_ctl),
    .x_i   (prep_x),
    .y_i   (prep_y),
    .z_i   (prep_z),
    .ctl_o (cordic_ctl),
    .z_o   (cordic_z)
  );

  bpc_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .ctl_i     (cordic_ctl),
    .z_i       (cordic_z),
    .valid_o   (out_valid),
    .heading_o (out_heading_centideg)
  );

endmodule

/* dv/bearing_to_point_centidegrees_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bearing_to_point_centidegrees_core_tb
// Self-checking bench: directed headings, random position pairs, stalled output.
// Each accepted item is run through a 64-bit CORDIC predictor. Every result
// is compared in order against the queue of predicted headings.
// ----------------------------------------------------------------------------
module bearing_to_point_centidegrees_core_tb;
  import bpc_pkg::*;

  localparam int     CYCLE_LIMIT   = 200000;
  localparam int     DRAIN_CYCLES  = 40;
  localparam int     STALL_CYCLES  = 300;
  localparam longint HALF_TURN_FX  = 64'sd18000 <<< ANG_FRAC;
  localparam longint FULL_TURN_FX  = 64'sd36000 <<< ANG_FRAC;
  localparam longint ROUND_HALF_FX = 64'sd1 <<< (ANG_FRAC - 1);

  logic     clk         = 1'b0;
  logic     rst_n       = 1'b0;
  logic     in_valid    = 1'b0;
  logic     in_ready;
  coord_t   in_robot_x  = '0;
  coord_t   in_robot_y  = '0;
  coord_t   in_goal_x   = '0;
  coord_t   in_goal_y   = '0;
  logic     out_valid;
  logic     out_ready   = 1'b0;
  heading_t out_heading_centideg;

  // atan(2^-i) in 2^-16 centidegree
  longint atan_step_fx [0:27] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466765, 733385, 366693, 183346, 91673, 45837,
    22918, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3
  };

  heading_t pending_headings[$];
  int       mismatch_count   = 0;
  int       unexpected_count = 0;
  int       positions_taken  = 0;
  int       headings_checked = 0;
  int       cycle_count      = 0;
  bit       sender_idles     = 1'b1;
  bit       receiver_idles   = 1'b1;
  bit       stall_request    = 1'b0;
  int       stall_left       = 0;

  bearing_to_point_centidegrees_core uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_robot_x           (in_robot_x),
    .in_robot_y           (in_robot_y),
    .in_goal_x            (in_goal_x),
    .in_goal_y            (in_goal_y),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_heading_centideg (out_heading_centideg)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Vectoring CORDIC on (dy, -dx), angle kept in 2^-16 centidegree.
  function automatic heading_t heading_toward(coord_t rx, coord_t ry, coord_t tx, coord_t ty);
    longint dx, dy, vx, vy, vx_next, ang, rounded;
    dx  = longint'(tx) - longint'(rx);
    dy  = longint'(ty) - longint'(ry);
    ang = 0;
    if (dx == 0 && dy == 0) return '0;
    vx = dy * (64'sd1 <<< VEC_SHIFT);
    vy = -dx * (64'sd1 <<< VEC_SHIFT);
    if (vx < 0) begin
      vx  = -vx;
      vy  = -vy;
      ang = HALF_TURN_FX;
    end
    for (int i = 0; i < N_ITER; i++) begin
      // y == 0 takes the negative direction
      if (vy > 0) begin
        vx_next = vx + (vy >>> i);
        vy      = vy - (vx >>> i);
        ang     = ang + atan_step_fx[i];
      end else begin
        vx_next = vx - (vy >>> i);
        vy      = vy + (vx >>> i);
        ang     = ang - atan_step_fx[i];
      end
      vx = vx_next;
    end
    if (ang < 0) ang = ang + FULL_TURN_FX;
    if (ang >= FULL_TURN_FX) ang = ang - FULL_TURN_FX;
    rounded = (ang + ROUND_HALF_FX) >>> ANG_FRAC;
    if (rounded >= 36000) rounded = rounded - 36000;
    return heading_t'(rounded);
  endfunction

  // Result check first, then record the new item; latency keeps them apart.
  always @(posedge clk) begin
    heading_t want;
    if (rst_n && out_valid && out_ready) begin
      headings_checked++;
      if (pending_headings.size() == 0) begin
        unexpected_count++;
        $display("[%0d] heading %0d arrived with none expected", cycle_count,
                 out_heading_centideg);
      end else begin
        want = pending_headings.pop_front();
        if (out_heading_centideg !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0d] heading mismatch: expected %0d, got %0d", cycle_count, want,
                     out_heading_centideg);
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      positions_taken++;
      pending_headings.push_back(heading_toward(in_robot_x, in_robot_y,
                                                in_goal_x, in_goal_y));
    end
  end

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_left    = STALL_CYCLES;
        stall_request = 1'b0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (receiver_idles) begin
        out_ready <= ($urandom_range(99) >= 36);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d headings outstanding", cycle_count,
               pending_headings.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Called right after a rising edge; returns at the edge that takes the item.
  task automatic send_position(input coord_t rx, input coord_t ry,
                               input coord_t tx, input coord_t ty);
    if (sender_idles) begin
      while ($urandom_range(99) < 36) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_robot_x <= rx;
    in_robot_y <= ry;
    in_goal_x  <= tx;
    in_goal_y  <= ty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic coord_t extreme_coord();
    case ($urandom_range(4))
      0:       return coord_t'(-32768);
      1:       return coord_t'(32767);
      2:       return coord_t'(0);
      3:       return coord_t'(-1);
      default: return coord_t'(1);
    endcase
  endfunction

  task automatic send_random_pair();
    coord_t rx, ry, tx, ty;
    int     pick;
    rx   = coord_t'($urandom);
    ry   = coord_t'($urandom);
    tx   = coord_t'($urandom);
    ty   = coord_t'($urandom);
    pick = $urandom_range(99);
    if (pick < 45) begin
      // full-range positions as drawn
    end else if (pick < 65) begin
      // short offsets: fine angles and small vectors
      tx = coord_t'(rx + $urandom_range(40) - 20);
      ty = coord_t'(ry + $urandom_range(40) - 20);
    end else if (pick < 75) begin
      if ($urandom_range(1)) tx = rx;
      else ty = ry;
    end else if (pick < 93) begin
      rx = extreme_coord();
      ry = extreme_coord();
      tx = extreme_coord();
      ty = extreme_coord();
    end else begin
      tx = rx;
      ty = ry;
    end
    send_position(rx, ry, tx, ty);
  endtask

  task automatic test_directed_headings();
    send_position(0, 0, 0, 0);                       // same position
    send_position(-32768, 32767, -32768, 32767);     // same position at the corner
    send_position(0, 0, 0, 100);                     // +Y
    send_position(0, 0, -100, 0);                    // -X
    send_position(0, 0, 0, -100);                    // -Y, pre-rotation with y zero
    send_position(0, 0, 100, 0);                     // +X
    send_position(0, 0, -7, 7);
    send_position(0, 0, -7, -7);
    send_position(0, 0, 7, -7);
    send_position(0, 0, 7, 7);
    send_position(-32768, -32768, 32767, 32767);     // largest positive differences
    send_position(32767, 32767, -32768, -32768);     // largest negative differences
    send_position(32767, -32768, -32768, 32767);
    send_position(-32768, 32767, 32767, -32768);
    send_position(0, -32768, 1, 32767);              // rounds up to a full turn
    send_position(0, -32768, -1, 32767);             // just past zero
    send_position(0, 0, 1, 32767);
    send_position(0, 32767, -1, -32768);             // just around half a turn
    send_position(0, 0, 0, 1);                       // unit vectors
    send_position(0, 0, -1, 0);
    send_position(0, 0, 0, -1);
    send_position(0, 0, 1, 0);
    send_position(-1, -1, -32768, -32768);
  endtask

  task automatic test_random_positions();
    for (int n = 0; n < 900; n++) begin
      // middle third runs with neither side idling
      sender_idles   = !(n >= 300 && n < 600);
      receiver_idles = !(n >= 300 && n < 600);
      send_random_pair();
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  // Receiver holds off while items keep coming, so the pipeline backs up.
  task automatic test_output_stall();
    sender_idles  = 1'b0;
    stall_request = 1'b1;
    for (int n = 0; n < 60; n++) send_random_pair();
    sender_idles  = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_headings();
    test_output_stall();
    test_random_positions();
    in_valid <= 1'b0;
    while (pending_headings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d position pairs, %0d headings checked: axes, diagonals, wrap, extremes,",
             positions_taken, headings_checked);
    $display("short and one-axis offsets, equal positions, and a long output stall.");
    if (mismatch_count == 0 && unexpected_count == 0 && pending_headings.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d unexpected, %0d missing", mismatch_count,
               unexpected_count, pending_headings.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
